[hdl/plst_pkg.sv]
`default_nettype none
package plst_pkg;

  // opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 5;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] value;
    logic [4:0]         position;
  } in_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [4:0]         entry_count;
  } out_t;

  // per-cell move control
  typedef struct packed {
    logic load;       // take the pushed word
    logic take_prev;  // shift down: take the entry above
    logic take_next;  // shift up: take the entry below
  } cell_ctl_t;

endpackage
`default_nettype wire

[hdl/positional_list_stack_top.sv]
`default_nettype none
// channel | ports                        | handshake
// input   | start, busy, in_data         | beat taken when start high and busy low
// result  | out_valid, out_data          | one-cycle strobe, one beat per input beat
//
// One push or pop is taken every cycle; busy stays low.
// Its result is registered at the accepting edge and shown for one cycle.
// The slots move in that same cycle: each cell of the chain loads the pushed
// word, its upper neighbor or its lower neighbor, or holds its value.
// Synchronous active-low reset empties the list; slot contents are not cleared.
// The receiver cannot stall, so no result is ever held back.
module positional_list_stack_top #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire plst_pkg::in_t  in_data,
  output logic                out_valid,
  output plst_pkg::out_t      out_data
);
  import plst_pkg::*;

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic              out_valid_r;
  out_t              out_r;
  out_t              out_nxt;

  logic              accept;
  logic [CMPW-1:0]   pos_w;
  logic [CMPW-1:0]   cnt_w;
  logic [CMPW-1:0]   at;
  logic              do_push;
  logic              do_pop;
  logic [1:0]        status;
  logic signed [31:0] popped;

  logic signed [31:0] vals [DEPTH];
  logic signed [31:0] hit  [DEPTH];
  cell_ctl_t          ctls [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pos_w  = CMPW'(in_data.position);
  assign cnt_w  = CMPW'(count_r);

  // decode the operation and the target slot
  always_comb begin
    do_push = 1'b0;
    do_pop  = 1'b0;
    status  = ST_OK;
    at      = pos_w - CMPW'(1);
    if (in_data.opcode == OP_PUSH) begin
      if (cnt_w >= CMPW'(DEPTH)) begin
        status = ST_FULL;
      end else begin
        do_push = accept;
        if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
          at = cnt_w;
        end
      end
    end else begin
      if (count_r == '0) begin
        status = ST_EMPTY;
      end else if (pos_w == '0 || pos_w > cnt_w) begin
        status = ST_RANGE;
      end else begin
        do_pop = accept;
      end
    end
  end

  // chain of slots, slot 0 is the top
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] prev_v;
    logic signed [31:0] next_v;

    if (g == 0) begin : g_first
      assign prev_v = '0;
    end else begin : g_mid_a
      assign prev_v = vals[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_v = '0;
    end else begin : g_mid_b
      assign next_v = vals[g+1];
    end

    assign ctls[g].load      = do_push && (at == CMPW'(g));
    assign ctls[g].take_prev = do_push && (CMPW'(g) > at);
    assign ctls[g].take_next = do_pop && (CMPW'(g) >= at) && (g != DEPTH - 1);

    assign hit[g] = (at == CMPW'(g)) ? vals[g] : '0;

    plst_cell u_cell (
      .clk      (clk),
      .ctl      (ctls[g]),
      .word     (in_data.value),
      .prev_val (prev_v),
      .next_val (next_v),
      .val      (vals[g])
    );
  end

  // pick the popped slot
  always_comb begin
    popped = '0;
    for (int i = 0; i < DEPTH; i++) begin
      popped = popped | hit[i];
    end
  end

  // count and result
  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CW'(1);
    end
    out_nxt              = out_r;
    out_nxt.popped_value = do_pop ? popped : '0;
    out_nxt.status       = status;
    out_nxt.entry_count  = POS_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

[hdl/plst_cell.sv]
`default_nettype none
module plst_cell (
  input  wire logic                clk,
  input  wire plst_pkg::cell_ctl_t ctl,
  input  wire logic signed [31:0]  word,
  input  wire logic signed [31:0]  prev_val,
  input  wire logic signed [31:0]  next_val,
  output logic signed [31:0]       val
);
  import plst_pkg::*;

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;

  // pick the source for this slot
  always_comb begin
    val_nxt = val_r;
    if (ctl.load) begin
      val_nxt = word;
    end else if (ctl.take_prev) begin
      val_nxt = prev_val;
    end else if (ctl.take_next) begin
      val_nxt = next_val;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule
`default_nettype wire
